FILE: rtl/bdc_pkg.sv
package bdc_pkg;

    // width of the millisecond tick counter, which moves once per processed sample, and its time stamps
    localparam int TIME_BITS = 32;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_HOLD        = 3'd1,
        REG_DIM_PERIOD  = 3'd2,
        REG_MIN_LEVEL   = 3'd3,
        REG_MAX_LEVEL   = 3'd4,
        REG_RAPID_WIN   = 3'd5,
        REG_RAPID_COUNT = 3'd6,
        REG_START_LEVEL = 3'd7
    } cfg_reg_t;

    // reset values of the registers
    localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [15:0] HOLD_RST        = 16'd500;
    localparam logic [15:0] DIM_PERIOD_RST  = 16'd10;
    localparam logic [7:0]  MIN_LEVEL_RST   = 8'd1;
    localparam logic [7:0]  MAX_LEVEL_RST   = 8'd255;
    localparam logic [15:0] RAPID_WIN_RST   = 16'd2000;
    localparam logic [3:0]  RAPID_COUNT_RST = 4'd5;
    localparam logic [7:0]  START_LEVEL_RST = 8'd128;

    // click counter saturation
    localparam logic [3:0]  CLICK_MAX = 4'd15;

endpackage

FILE: rtl/button_dimmer_controller.sv
// path: an input transfer goes through the input register and then the result register
// throughput: one button sample per cycle; an empty input register takes a new sample
// while a result waits, a full one stalls the input as long as the result is stalled
// reset: asynchronous, active low; registers take their defaults, the light is off,
// the level is the default start level (128), the dimming direction is up
module button_dimmer_controller
    import bdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,

    // button samples, one per millisecond tick
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     button_raw,

    // results
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     light_on,
    output logic [7:0]               level,
    output logic                     changed,
    output logic                     save_request,
    output logic                     radio_off,
    output logic                     radio_toggled,
    output logic                     dim_upward
);

    // configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] hold_reg;
    logic [15:0] dim_period_reg;
    logic [7:0]  min_level_reg;
    logic [7:0]  max_level_reg;
    logic [15:0] rapid_win_reg;
    logic [3:0]  rapid_count_reg;

    // controller state
    logic [TIME_BITS-1:0] tick_reg,   tick_next;
    logic [TIME_BITS-1:0] chg_stamp_reg, chg_stamp_next;
    logic [TIME_BITS-1:0] press_stamp_reg, press_stamp_next;
    logic [TIME_BITS-1:0] dim_stamp_reg, dim_stamp_next;
    logic [TIME_BITS-1:0] win_start_reg, win_start_next;
    logic                 last_sample_reg, last_sample_next;
    logic                 stable_reg, stable_next;
    logic                 holding_reg, holding_next;
    logic                 dir_up_reg, dir_up_next;
    logic                 lamp_reg, lamp_next;
    logic                 radio_reg, radio_next;
    logic [3:0]           clicks_reg, clicks_next;
    logic [7:0]           bright_reg, bright_next;

    // pipeline registers
    logic                 in_vld_reg;
    logic                 in_btn_reg;
    logic                 out_vld_reg;
    logic                 light_reg;
    logic [7:0]           level_reg;
    logic                 changed_reg, changed_next;
    logic                 save_reg, save_next;
    logic                 radio_out_reg;
    logic                 toggled_reg, toggled_next;
    logic                 dir_out_reg;

    logic                 advance;
    logic                 in_take;

    // per-tick intermediate values
    logic                 deb_ok;
    logic                 stable_edge;
    logic                 hold_ok;
    logic                 dim_due;
    logic                 win_expired;
    logic [3:0]           clicks_inc;
    logic [7:0]           level_click;
    logic [7:0]           level_step;

    // handshake
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RST;
            hold_reg        <= HOLD_RST;
            dim_period_reg  <= DIM_PERIOD_RST;
            min_level_reg   <= MIN_LEVEL_RST;
            max_level_reg   <= MAX_LEVEL_RST;
            rapid_win_reg   <= RAPID_WIN_RST;
            rapid_count_reg <= RAPID_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:    debounce_reg    <= cfg_data;
                REG_HOLD:        hold_reg        <= cfg_data;
                REG_DIM_PERIOD:  dim_period_reg  <= cfg_data;
                REG_MIN_LEVEL:   min_level_reg   <= cfg_data[7:0];
                REG_MAX_LEVEL:   max_level_reg   <= cfg_data[7:0];
                REG_RAPID_WIN:   rapid_win_reg   <= cfg_data;
                REG_RAPID_COUNT: rapid_count_reg <= cfg_data[3:0];
                // start level writes are ignored; reset always loads the default start level
                REG_START_LEVEL: ;
                default:         ;
            endcase
        end
    end

    // one tick of the controller
    always_comb
    begin
        chg_stamp_next   = chg_stamp_reg;
        press_stamp_next = press_stamp_reg;
        dim_stamp_next   = dim_stamp_reg;
        win_start_next   = win_start_reg;
        stable_next      = stable_reg;
        holding_next     = holding_reg;
        dir_up_next      = dir_up_reg;
        lamp_next        = lamp_reg;
        radio_next       = radio_reg;
        clicks_next      = clicks_reg;
        changed_next     = 1'b0;
        save_next        = 1'b0;
        toggled_next     = 1'b0;
        level_click      = bright_reg;
        level_step       = bright_reg;
        bright_next      = bright_reg;

        // debounce: a change this tick restarts the stable time at zero
        if (in_btn_reg != last_sample_reg)
        begin
            chg_stamp_next = tick_reg;
            deb_ok         = 1'b0;
        end
        else
        begin
            deb_ok = (tick_reg - chg_stamp_reg) > TIME_BITS'(debounce_reg);
        end
        stable_edge = deb_ok && (in_btn_reg != stable_reg);

        win_expired = (tick_reg - win_start_reg) > TIME_BITS'(rapid_win_reg);
        clicks_inc  = (clicks_reg < CLICK_MAX) ? 4'(clicks_reg + 4'd1) : clicks_reg;

        // debounced edge
        if (stable_edge)
        begin
            stable_next = in_btn_reg;
            if (in_btn_reg)
            begin
                press_stamp_next = tick_reg;
            end
            else if (holding_reg)
            begin
                holding_next = 1'b0;
                dir_up_next  = !dir_up_reg;
                save_next    = 1'b1;
            end
            else
            begin
                // click: toggle the light, clamp on turn-on, count rapid clicks
                lamp_next    = !lamp_reg;
                changed_next = 1'b1;
                save_next    = 1'b1;
                if (!lamp_reg)
                begin
                    if (bright_reg < min_level_reg)
                        level_click = min_level_reg;
                    else if (bright_reg > max_level_reg)
                        level_click = max_level_reg;
                end
                if (win_expired)
                begin
                    win_start_next = tick_reg;
                    clicks_next    = 4'd1;
                end
                else
                begin
                    clicks_next = clicks_inc;
                end
                if (clicks_next >= rapid_count_reg)
                begin
                    clicks_next  = 4'd0;
                    radio_next   = !radio_reg;
                    toggled_next = 1'b1;
                end
            end
        end

        // hold dimming; a press edge this tick has zero elapsed time
        hold_ok = stable_reg && !stable_edge
                  && ((tick_reg - press_stamp_reg) > TIME_BITS'(hold_reg));
        dim_due = (tick_reg - dim_stamp_reg) >= TIME_BITS'(dim_period_reg);

        if (dir_up_reg)
            level_step = (level_click < max_level_reg) ? 8'(level_click + 8'd1)
                                                       : max_level_reg;
        else
            level_step = (level_click > min_level_reg) ? 8'(level_click - 8'd1)
                                                       : min_level_reg;
        if (level_step < min_level_reg)
            level_step = min_level_reg;
        else if (level_step > max_level_reg)
            level_step = max_level_reg;

        bright_next = level_click;
        if (hold_ok)
        begin
            holding_next = 1'b1;
            lamp_next    = 1'b1;
            if (dim_due)
            begin
                dim_stamp_next = tick_reg;
                bright_next    = level_step;
                changed_next   = 1'b1;
            end
        end

        last_sample_next = in_btn_reg;
        tick_next        = TIME_BITS'(tick_reg + 1'b1);
    end

    // state update and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            chg_stamp_reg   <= '0;
            press_stamp_reg <= '0;
            dim_stamp_reg   <= '0;
            win_start_reg   <= '0;
            last_sample_reg <= 1'b0;
            stable_reg      <= 1'b0;
            holding_reg     <= 1'b0;
            dir_up_reg      <= 1'b1;
            lamp_reg        <= 1'b0;
            radio_reg       <= 1'b0;
            clicks_reg      <= '0;
            bright_reg      <= START_LEVEL_RST;
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            // input register
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            // result register
            if (advance)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                tick_reg        <= tick_next;
                chg_stamp_reg   <= chg_stamp_next;
                press_stamp_reg <= press_stamp_next;
                dim_stamp_reg   <= dim_stamp_next;
                win_start_reg   <= win_start_next;
                last_sample_reg <= last_sample_next;
                stable_reg      <= stable_next;
                holding_reg     <= holding_next;
                dir_up_reg      <= dir_up_next;
                lamp_reg        <= lamp_next;
                radio_reg       <= radio_next;
                clicks_reg      <= clicks_next;
                bright_reg      <= bright_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_btn_reg <= button_raw;
        if (advance)
        begin
            light_reg     <= lamp_next;
            level_reg     <= bright_next;
            changed_reg   <= changed_next;
            save_reg      <= save_next;
            radio_out_reg <= radio_next;
            toggled_reg   <= toggled_next;
            dir_out_reg   <= dir_up_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign light_on      = light_reg;
    assign level         = level_reg;
    assign changed       = changed_reg;
    assign save_request  = save_reg;
    assign radio_off     = radio_out_reg;
    assign radio_toggled = toggled_reg;
    assign dim_upward    = dir_out_reg;

    // a radio toggle only comes from a click, which always announces a change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radio_toggled |-> changed)
        else $error("radio toggle without change pulse");

    // a save without a change is a hold release, which reverses the direction
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && save_next && !changed_next |-> dir_up_next != dir_up_reg)
        else $error("hold release did not reverse direction");

    // an empty input register never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> !in_stall)
        else $error("stall with empty input register");

    // the tick counter moves by exactly one per processed sample
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> tick_reg == TIME_BITS'($past(tick_reg) + 1'b1))
        else $error("tick counter out of step");

endmodule

FILE: verif/dimmer_checker.sv
`timescale 1ns / 1ps
module dimmer_checker
    import bdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     button_raw,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     light_on,
    input  logic [7:0]               level,
    input  logic                     changed,
    input  logic                     save_request,
    input  logic                     radio_off,
    input  logic                     radio_toggled,
    input  logic                     dim_upward,
    output int                       fail_count,
    output int                       outstanding
);

    typedef struct packed {
        logic       light_on;
        logic [7:0] level;
        logic       changed;
        logic       save_request;
        logic       radio_off;
        logic       radio_toggled;
        logic       dim_upward;
    } lamp_state_t;

    lamp_state_t expected_lamp_q[$];

    // register copies
    logic [15:0] debounce_len, hold_len, dim_period, window_len;
    logic [7:0]  min_lvl, max_lvl, start_lvl;
    logic [3:0]  rapid_cnt;

    // dimmer state
    logic [TIME_BITS-1:0] now_tick, change_t, press_t, dim_t, window_t;
    logic                 sample_q, button_q, holding_q, dir_up, lamp_q, radio_q;
    logic [3:0]           clicks;
    logic [7:0]           bright;

    // ticks since a stamp, wrapping
    function automatic logic [TIME_BITS-1:0] since(input logic [TIME_BITS-1:0] stamp);
        return now_tick - stamp;
    endfunction

    // when the range is inverted, values below min go to min and all others to max
    function automatic logic [7:0] clamp_to_range(input logic [7:0] x);
        if (x < min_lvl)
            return min_lvl;
        else if (x > max_lvl)
            return max_lvl;
        return x;
    endfunction

    // one millisecond tick of the dimmer
    task automatic step_dimmer(input logic reading, output lamp_state_t r);
        logic chg, save, tog;
        chg  = 1'b0;
        save = 1'b0;
        tog  = 1'b0;

        if (reading != sample_q)
            change_t = now_tick;

        // debounced edge
        if (since(change_t) > debounce_len && reading != button_q)
        begin
            button_q = reading;
            if (button_q)
            begin
                press_t = now_tick;
            end
            else if (holding_q)
            begin
                holding_q = 1'b0;
                dir_up    = !dir_up;
                save      = 1'b1;
            end
            else
            begin
                lamp_q = !lamp_q;
                if (lamp_q)
                    bright = clamp_to_range(bright);
                chg  = 1'b1;
                save = 1'b1;
                // rapid click counting
                if (since(window_t) > window_len)
                begin
                    window_t = now_tick;
                    clicks   = 4'd1;
                end
                else if (clicks < CLICK_MAX)
                begin
                    clicks = clicks + 4'd1;
                end
                if (clicks >= rapid_cnt)
                begin
                    clicks  = 4'd0;
                    radio_q = !radio_q;
                    tog     = 1'b1;
                end
            end
        end

        // hold dimming
        if (button_q && since(press_t) > hold_len)
        begin
            holding_q = 1'b1;
            lamp_q    = 1'b1;
            if (since(dim_t) >= dim_period)
            begin
                dim_t = now_tick;
                if (dir_up)
                begin
                    if (bright < max_lvl)
                        bright = bright + 8'd1;
                    if (bright > max_lvl)
                        bright = max_lvl;
                end
                else
                begin
                    if (bright > min_lvl)
                        bright = bright - 8'd1;
                    if (bright < min_lvl)
                        bright = min_lvl;
                end
                bright = clamp_to_range(bright);
                chg    = 1'b1;
            end
        end

        sample_q = reading;
        now_tick = now_tick + 1'b1;
        r = '{lamp_q, bright, chg, save, radio_q, tog, dir_up};
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        lamp_state_t want, got;
        if (!rst_n)
        begin
            debounce_len = DEBOUNCE_RST;
            hold_len     = HOLD_RST;
            dim_period   = DIM_PERIOD_RST;
            min_lvl      = MIN_LEVEL_RST;
            max_lvl      = MAX_LEVEL_RST;
            window_len   = RAPID_WIN_RST;
            rapid_cnt    = RAPID_COUNT_RST;
            start_lvl    = START_LEVEL_RST;
            now_tick     = '0;
            change_t     = '0;
            press_t      = '0;
            dim_t        = '0;
            window_t     = '0;
            sample_q     = 1'b0;
            button_q     = 1'b0;
            holding_q    = 1'b0;
            dir_up       = 1'b1;
            lamp_q       = 1'b0;
            radio_q      = 1'b0;
            clicks       = 4'd0;
            bright       = start_lvl;
            expected_lamp_q.delete();
            fail_count   = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DEBOUNCE:    debounce_len = cfg_data;
                    REG_HOLD:        hold_len     = cfg_data;
                    REG_DIM_PERIOD:  dim_period   = cfg_data;
                    REG_MIN_LEVEL:   min_lvl      = cfg_data[7:0];
                    REG_MAX_LEVEL:   max_lvl      = cfg_data[7:0];
                    REG_RAPID_WIN:   window_len   = cfg_data;
                    REG_RAPID_COUNT: rapid_cnt    = cfg_data[3:0];
                    REG_START_LEVEL: start_lvl    = cfg_data[7:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = '{light_on, level, changed, save_request, radio_off, radio_toggled,
                        dim_upward};
                if (expected_lamp_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_lamp_q.pop_front();
                    if (got.light_on !== want.light_on)
                    begin
                        $error("light_on: expected %0d, actual %0d", want.light_on, got.light_on);
                        fail_count++;
                    end
                    if (got.level !== want.level)
                    begin
                        $error("level: expected %0d, actual %0d", want.level, got.level);
                        fail_count++;
                    end
                    if (got.changed !== want.changed)
                    begin
                        $error("changed: expected %0d, actual %0d", want.changed, got.changed);
                        fail_count++;
                    end
                    if (got.save_request !== want.save_request)
                    begin
                        $error("save_request: expected %0d, actual %0d",
                               want.save_request, got.save_request);
                        fail_count++;
                    end
                    if (got.radio_off !== want.radio_off)
                    begin
                        $error("radio_off: expected %0d, actual %0d",
                               want.radio_off, got.radio_off);
                        fail_count++;
                    end
                    if (got.radio_toggled !== want.radio_toggled)
                    begin
                        $error("radio_toggled: expected %0d, actual %0d",
                               want.radio_toggled, got.radio_toggled);
                        fail_count++;
                    end
                    if (got.dim_upward !== want.dim_upward)
                    begin
                        $error("dim_upward: expected %0d, actual %0d",
                               want.dim_upward, got.dim_upward);
                        fail_count++;
                    end
                end
            end

            // sample transfer
            if (in_valid && !in_stall)
            begin
                step_dimmer(button_raw, want);
                expected_lamp_q.push_back(want);
            end
        end
        outstanding = expected_lamp_q.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import bdc_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_STALL  = 80;
    localparam int RUN_CAP     = 60;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     button_raw = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     light_on;
    logic [7:0]               level;
    logic                     changed;
    logic                     save_request;
    logic                     radio_off;
    logic                     radio_toggled;
    logic                     dim_upward;

    int fail_count;
    int outstanding;
    int send_idle_pct = 21;
    int recv_idle_pct = 48;
    int long_stall_asked = 0;
    int long_stall_given = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    // timing registers as last written, used to shape presses
    int cur_deb  = DEBOUNCE_RST;
    int cur_hold = HOLD_RST;
    int cur_dimp = DIM_PERIOD_RST;
    int cur_win  = RAPID_WIN_RST;

    button_dimmer_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_raw   (button_raw),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .light_on     (light_on),
        .level        (level),
        .changed      (changed),
        .save_request (save_request),
        .radio_off    (radio_off),
        .radio_toggled(radio_toggled),
        .dim_upward   (dim_upward)
    );

    dimmer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_raw   (button_raw),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .light_on     (light_on),
        .level        (level),
        .changed      (changed),
        .save_request (save_request),
        .radio_off    (radio_off),
        .radio_toggled(radio_toggled),
        .dim_upward   (dim_upward),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side stall, random or a long hold-off on request
    always @(negedge clk)
    begin
        if (long_stall_asked != long_stall_given)
        begin
            long_stall_given <= long_stall_given + 1;
            stall_left       <= LONG_STALL;
            out_stall        <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one sample transfer, starting and ending at a falling edge
    task automatic send_sample(input logic b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        button_raw <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_run(input logic b, input int n);
        repeat (n) send_sample(b);
    endtask

    // wait until every result is back, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write all registers, narrow ones with junk in the unused upper bits
    task automatic configure(input logic [15:0] deb, input logic [15:0] hold,
                             input logic [15:0] dimp, input logic [15:0] win,
                             input logic [7:0] lo, input logic [7:0] hi,
                             input logic [7:0] start, input logic [3:0] rapid);
        logic [15:0] vals [8];
        settle();
        vals[REG_DEBOUNCE]    = deb;
        vals[REG_HOLD]        = hold;
        vals[REG_DIM_PERIOD]  = dimp;
        vals[REG_MIN_LEVEL]   = {8'($urandom), lo};
        vals[REG_MAX_LEVEL]   = {8'($urandom), hi};
        vals[REG_RAPID_WIN]   = win;
        vals[REG_RAPID_COUNT] = {12'($urandom), rapid};
        vals[REG_START_LEVEL] = {8'($urandom), start};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we   <= 1'b0;
        cur_deb  = deb;
        cur_hold = hold;
        cur_dimp = dimp;
        cur_win  = win;
    endtask

    // mostly well-formed clicks and holds, some glitch noise
    task automatic run_phase(input int n_items);
        int sent, kind, press_len, rest_len, glitch_len;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                press_len = cur_deb + 2 + $urandom_range(0, cur_hold + 4 * cur_dimp + 4);
                if (press_len > RUN_CAP)
                    press_len = RUN_CAP;
                if (kind < 60)
                    rest_len = cur_deb + 2 + $urandom_range(0, 6);
                else
                    rest_len = cur_deb + 2 + $urandom_range(0, cur_win + 10);
                if (rest_len > RUN_CAP)
                    rest_len = RUN_CAP;
                send_run(1'b1, press_len);
                send_run(1'b0, rest_len);
                sent += press_len + rest_len;
            end
            else
            begin
                glitch_len = $urandom_range(1, 6);
                repeat (glitch_len) send_sample(1'($urandom));
                sent += glitch_len;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic [7:0] lo;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: defaults, then click on with clamp, click off toggling radio,
        // hold at max, release reversing direction, hold dimming down
        send_sample(1'b0);
        send_sample(1'b1);
        configure(16'd0, 16'd2, 16'd0, 16'd30, 8'd10, 8'd20, 8'd99, 4'd2);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 6);
        send_run(1'b0, 2);
        send_run(1'b1, 7);
        send_run(1'b0, 2);

        // random phases over several register settings
        for (int p = 0; p < 14; p++)
        begin
            lo = 8'($urandom_range(0, 230));
            case (p)
                // zero times, full range, every click toggles the radio
                0: configure(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd255, 8'd0, 4'd0);
                // min above max
                1: configure(16'd1, 16'd6, 16'd1, 16'd40, 8'd200, 8'd50, 8'd255, 4'd15);
                // all timing registers at their maximum
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255,
                             8'd255, 4'd15);
                // click counter reaching its maximum inside a huge window
                3: configure(16'd2, 16'd8, 16'd0, 16'hFFFF, 8'd255, 8'd255, 8'd0, 4'd15);
                default: configure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 20)),
                                   16'($urandom_range(0, 4)), 16'($urandom_range(5, 120)),
                                   lo, lo + 8'($urandom_range(0, 25)),
                                   8'($urandom), 4'($urandom_range(1, 6)));
            endcase

            if (p == 5)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 21;
            end
            else if (p == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 6 || p == 11)
                long_stall_asked++;

            run_phase((p == 2) ? 40 : 105);
        end

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
